// ----- hw/rtl/mnp_pkg.sv -----
// Package with the shared types, character codes and key lookup of the MML note parser.
`timescale 1ns / 1ps
`default_nettype none
package mnp_pkg;

  localparam int unsigned SYMBOL_W = 8;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned OCT_W    = 4;
  localparam int unsigned KEY_W    = 6;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam logic [SYMBOL_W-1:0] CH_L     = 8'h4C;
  localparam logic [SYMBOL_W-1:0] CH_O     = 8'h4F;
  localparam logic [SYMBOL_W-1:0] CH_LT    = 8'h3C;
  localparam logic [SYMBOL_W-1:0] CH_GT    = 8'h3E;
  localparam logic [SYMBOL_W-1:0] CH_A     = 8'h41;
  localparam logic [SYMBOL_W-1:0] CH_B     = 8'h42;
  localparam logic [SYMBOL_W-1:0] CH_C     = 8'h43;
  localparam logic [SYMBOL_W-1:0] CH_D     = 8'h44;
  localparam logic [SYMBOL_W-1:0] CH_E     = 8'h45;
  localparam logic [SYMBOL_W-1:0] CH_F     = 8'h46;
  localparam logic [SYMBOL_W-1:0] CH_G     = 8'h47;
  localparam logic [SYMBOL_W-1:0] CH_DIG1  = 8'h31;
  localparam logic [SYMBOL_W-1:0] CH_DIG2  = 8'h32;
  localparam logic [SYMBOL_W-1:0] CH_DIG4  = 8'h34;
  localparam logic [SYMBOL_W-1:0] CH_DIG8  = 8'h38;

  localparam logic [LEN_W-1:0]   LEN_HALF   = 4'd2;
  localparam logic [LEN_W-1:0]   LEN_RESET  = 4'd4;
  localparam logic [LEN_W-1:0]   LEN_EIGHTH = 4'd8;
  localparam logic [OCT_W-1:0]   OCT_RESET  = 4'd4;
  localparam logic [OCT_W-1:0]   OCT_MIN    = 4'd0;
  localparam logic [OCT_W-1:0]   OCT_MAX    = 4'd15;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;
  localparam logic [KEY_W:0]     KEY_STEP   = 7'd12;

  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol;
    logic                track_start;
  } mnp_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key_number;
    logic [LEN_W-1:0]   note_length;
    logic [COUNT_W-1:0] slot_index;
    logic [COUNT_W-1:0] note_seq;
  } mnp_note_t;

  function automatic logic [KEY_W:0] base_key(input logic [SYMBOL_W-1:0] ch);
    logic [KEY_W:0] b;
    b = '0;
    case (ch)
      CH_C:    b = 7'd13;
      CH_D:    b = 7'd15;
      CH_E:    b = 7'd17;
      CH_F:    b = 7'd18;
      CH_G:    b = 7'd20;
      CH_A:    b = 7'd22;
      CH_B:    b = 7'd24;
      default: b = '0;
    endcase
    return b;
  endfunction

  function automatic logic [KEY_W-1:0] key_for(input logic [OCT_W-1:0] oct,
                                               input logic [SYMBOL_W-1:0] ch);
    logic [KEY_W:0] b;
    logic [KEY_W:0] k;
    b = base_key(ch);
    case (oct)
      4'd3:    k = b - KEY_STEP;
      4'd4:    k = b;
      4'd5:    k = b + KEY_STEP;
      4'd6:    k = b + (KEY_STEP << 1);
      4'd7:    k = b + (KEY_STEP << 1) + KEY_STEP;
      default: k = '0;
    endcase
    return k[KEY_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/mml_note_parser_top.sv -----
// Top level of the MML note parser: input register, parser core and result register.
//
// The input channel takes one ASCII character of a track per request, with
// tuser set on the first character of a track to restart the parser state.
// Each note letter from A to G produces one result request carrying its
// running order, record slot, length divisor and piano key number; every
// other character only updates the parser state and produces nothing.
// A character is parsed while it sits in the input register, and its note is
// loaded into the result register when the parser takes it, which raises
// out_tvalid. One character is accepted every cycle unless a note character
// waits for the result register; the parser core updates its state per character.
// After reset the parser holds length 4, octave 4 and zero counts, and both
// channels are empty. When the receiver stalls, the result register holds
// its note; a non-note character still passes through, and a note character
// waits in the input register, which then holds back the input channel.
`timescale 1ns / 1ps
`default_nettype none
module mml_note_parser_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] symbol
  input  wire logic [0:0]  in_tuser,   // [0] track_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata   // [15:0] note_seq, [31:16] slot_index,
                                       // [35:32] note_length, [41:36] key_number
);
  import mnp_pkg::*;

  mnp_item_t in_item;
  mnp_item_t item;
  mnp_note_t note;
  mnp_note_t out_note;
  logic      item_valid;
  logic      take;
  logic      note_load;
  logic      slot_free;

  assign in_item.symbol      = in_tdata;
  assign in_item.track_start = in_tuser[0];

  mnp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  mnp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .slot_free  (slot_free),
    .take       (take),
    .note_load  (note_load),
    .note       (note)
  );

  mnp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .note_load  (note_load),
    .note       (note),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_note   (out_note)
  );

  assign out_tdata = {6'd0, out_note};

endmodule
`default_nettype wire

// ----- hw/rtl/mnp_in_stage.sv -----
// Input register that holds one accepted character request until the parser takes it.
`timescale 1ns / 1ps
`default_nettype none
module mnp_in_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire mnp_pkg::mnp_item_t in_item,
  input  wire logic               take,
  output logic                    item_valid,
  output mnp_pkg::mnp_item_t      item
);
  import mnp_pkg::*;

  logic      valid_r;
  mnp_item_t item_r;

  assign in_tready  = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/mnp_core.sv -----
// Parser state and the per-character update that forms each note request.
`timescale 1ns / 1ps
`default_nettype none
module mnp_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               item_valid,
  input  wire mnp_pkg::mnp_item_t item,
  input  wire logic               slot_free,
  output logic                    take,
  output logic                    note_load,
  output mnp_pkg::mnp_note_t      note
);
  import mnp_pkg::*;

  logic               await_len_r, await_len_nxt;
  logic               await_oct_r, await_oct_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [OCT_W-1:0]   oct_r, oct_nxt;
  logic [COUNT_W-1:0] order_r, order_nxt;
  logic [COUNT_W-1:0] slot_r, slot_nxt;
  logic [COUNT_W-1:0] order_cur, slot_cur;
  logic [COUNT_W:0]   slot_sum;
  logic               is_note;
  logic [SYMBOL_W-1:0] ch;

  assign ch      = item.symbol;
  assign is_note = (ch >= CH_A) && (ch <= CH_G);
  assign take      = item_valid && (!is_note || slot_free);
  assign note_load = take && is_note;

  always_comb begin
    await_len_nxt = await_len_r;
    await_oct_nxt = await_oct_r;
    len_nxt       = len_r;
    oct_nxt       = oct_r;
    order_cur     = order_r;
    slot_cur      = slot_r;
    if (item.track_start) begin
      await_len_nxt = 1'b0;
      await_oct_nxt = 1'b0;
      len_nxt       = LEN_RESET;
      oct_nxt       = OCT_RESET;
      order_cur     = '0;
      slot_cur      = '0;
    end
    if (await_len_nxt) begin
      if (ch == CH_DIG2 || ch == CH_DIG4 || ch == CH_DIG8) begin
        len_nxt = ch[LEN_W-1:0];
      end
      await_len_nxt = 1'b0;
    end
    if (await_oct_nxt) begin
      if (ch >= CH_DIG1 && ch <= CH_DIG8) begin
        oct_nxt = ch[OCT_W-1:0];
      end
      await_oct_nxt = 1'b0;
    end
    order_nxt = order_cur;
    slot_nxt  = slot_cur;
    slot_sum  = {1'b0, slot_cur} + ((len_nxt == LEN_HALF) ? 17'd2 : 17'd1);
    if (ch == CH_L) begin
      await_len_nxt = 1'b1;
    end else if (ch == CH_O) begin
      await_oct_nxt = 1'b1;
    end else if (ch == CH_LT) begin
      if (oct_nxt != OCT_MIN) begin
        oct_nxt = oct_nxt - 4'd1;
      end
    end else if (ch == CH_GT) begin
      if (oct_nxt != OCT_MAX) begin
        oct_nxt = oct_nxt + 4'd1;
      end
    end else if (is_note) begin
      if (order_cur != COUNT_MAX) begin
        order_nxt = order_cur + 16'd1;
      end
      slot_nxt = slot_sum[COUNT_W] ? COUNT_MAX : slot_sum[COUNT_W-1:0];
    end
  end

  assign note.note_seq    = order_cur;
  assign note.slot_index  = slot_cur;
  assign note.note_length = len_nxt;
  assign note.key_number  = key_for(oct_nxt, ch);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_len_r <= 1'b0;
      await_oct_r <= 1'b0;
      len_r       <= LEN_RESET;
      oct_r       <= OCT_RESET;
      order_r     <= '0;
      slot_r      <= '0;
    end else if (take) begin
      await_len_r <= await_len_nxt;
      await_oct_r <= await_oct_nxt;
      len_r       <= len_nxt;
      oct_r       <= oct_nxt;
      order_r     <= order_nxt;
      slot_r      <= slot_nxt;
    end
  end

  a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r == LEN_HALF) || (len_r == LEN_RESET) || (len_r == LEN_EIGHTH))
    else $error("note length register left the set of divisors");

  a_one_capture: assert property (@(posedge clk) disable iff (!rst_n)
    !(await_len_r && await_oct_r))
    else $error("length and octave capture armed together");

  a_order_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !item.track_start) |=> (order_r >= $past(order_r)))
    else $error("note order went backward without a track start");

  a_note_only_on_letter: assert property (@(posedge clk) disable iff (!rst_n)
    note_load |-> (note.note_seq == (item.track_start ? 16'd0 : order_r)))
    else $error("emitted order does not match the running count");

endmodule
`default_nettype wire

// ----- hw/rtl/mnp_out_stage.sv -----
// Result register that holds one note request until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none
module mnp_out_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               note_load,
  input  wire mnp_pkg::mnp_note_t note,
  output logic                    slot_free,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output mnp_pkg::mnp_note_t      out_note
);
  import mnp_pkg::*;

  logic      valid_r;
  mnp_note_t note_r;

  assign slot_free  = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_note   = note_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (note_load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (note_load) begin
      note_r <= note;
    end
  end

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the MML note parser: directed and random character streams against a note predictor.
`timescale 1ns / 1ps
module testbench;
  import mnp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned PHASE_LEN   = 350;
  localparam int unsigned RANDOM_ITEMS = 1050;
  localparam logic [SYMBOL_W-1:0] SYM_NINE    = 8'h39;
  localparam logic [SYMBOL_W-1:0] SYM_LOWER_C = 8'h63;
  localparam logic [SYMBOL_W-1:0] SYM_ZERO    = 8'h00;
  localparam logic [SYMBOL_W-1:0] SYM_ALL_ONE = 8'hFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  mnp_item_t track_chars[$];
  mnp_note_t expected_notes[$];
  int unsigned chars_taken = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  logic len_armed;
  logic oct_armed;
  logic [LEN_W-1:0] cur_length;
  logic [OCT_W-1:0] cur_octave;
  logic [COUNT_W-1:0] notes_seen;
  logic [COUNT_W-1:0] next_slot;

  mml_note_parser_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned idle_pct(input bit for_sender);
    int unsigned phase;
    phase = chars_taken / PHASE_LEN;
    if (phase == 0) begin
      return for_sender ? 8 : 82;
    end else if (phase == 1) begin
      return for_sender ? 82 : 8;
    end
    return 0;
  endfunction

  function automatic logic [KEY_W-1:0] piano_key(input logic [OCT_W-1:0] oct,
                                                 input logic [SYMBOL_W-1:0] sym);
    int base;
    case (sym)
      CH_C: base = 13;
      CH_D: base = 15;
      CH_E: base = 17;
      CH_F: base = 18;
      CH_G: base = 20;
      CH_A: base = 22;
      CH_B: base = 24;
      default: base = 0;
    endcase
    if (oct < 3 || oct > 7) begin
      return '0;
    end
    return KEY_W'(base + 12 * (int'(oct) - 4));
  endfunction

  task automatic clear_parser();
    len_armed = 1'b0;
    oct_armed = 1'b0;
    cur_length = LEN_RESET;
    cur_octave = OCT_RESET;
    notes_seen = '0;
    next_slot = '0;
  endtask

  task automatic parse_char(input mnp_item_t it);
    logic [SYMBOL_W-1:0] sym;
    logic [SYMBOL_W-1:0] oct_digit;
    mnp_note_t note;
    int slot_sum;
    sym = it.symbol;
    if (it.track_start) begin
      clear_parser();
    end
    if (len_armed) begin
      if (sym == CH_DIG2) cur_length = LEN_HALF;
      else if (sym == CH_DIG4) cur_length = LEN_RESET;
      else if (sym == CH_DIG8) cur_length = LEN_EIGHTH;
      len_armed = 1'b0;
    end
    if (oct_armed) begin
      if (sym >= CH_DIG1 && sym <= CH_DIG8) begin
        oct_digit = sym - CH_DIG1;
        cur_octave = oct_digit[OCT_W-1:0] + 4'd1;
      end
      oct_armed = 1'b0;
    end
    if (sym == CH_L) begin
      len_armed = 1'b1;
    end else if (sym == CH_O) begin
      oct_armed = 1'b1;
    end else if (sym == CH_LT) begin
      if (cur_octave != OCT_MIN) cur_octave = cur_octave - 4'd1;
    end else if (sym == CH_GT) begin
      if (cur_octave != OCT_MAX) cur_octave = cur_octave + 4'd1;
    end else if (sym >= CH_A && sym <= CH_G) begin
      note.note_seq = notes_seen;
      note.slot_index = next_slot;
      note.note_length = cur_length;
      note.key_number = piano_key(cur_octave, sym);
      expected_notes.push_back(note);
      if (notes_seen != COUNT_MAX) notes_seen = notes_seen + 16'd1;
      slot_sum = int'(next_slot) + ((cur_length == LEN_HALF) ? 2 : 1);
      next_slot = (slot_sum > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(slot_sum);
    end
  endtask

  task automatic add_char(input logic [SYMBOL_W-1:0] sym, input logic start);
    mnp_item_t it;
    it.symbol = sym;
    it.track_start = start;
    track_chars.push_back(it);
  endtask

  function automatic logic [SYMBOL_W-1:0] random_letter();
    return CH_A + SYMBOL_W'($urandom_range(6));
  endfunction

  task automatic add_random_phrase();
    int unsigned r;
    int unsigned run;
    r = $urandom_range(99);
    if (r < 45) begin
      add_char(random_letter(), 1'b0);
    end else if (r < 55) begin
      add_char(CH_L, 1'b0);
      case ($urandom_range(4))
        0: add_char(CH_DIG2, 1'b0);
        1: add_char(CH_DIG4, 1'b0);
        2: add_char(CH_DIG8, 1'b0);
        3: add_char(random_letter(), 1'b0);
        default: add_char(SYMBOL_W'($urandom_range(255)), 1'b0);
      endcase
    end else if (r < 65) begin
      add_char(CH_O, 1'b0);
      if ($urandom_range(4) != 0) begin
        add_char(CH_DIG1 + SYMBOL_W'($urandom_range(7)), 1'b0);
      end else begin
        add_char(SYMBOL_W'($urandom_range(255)), 1'b0);
      end
    end else if (r < 85) begin
      run = ($urandom_range(5) == 0) ? $urandom_range(10, 17) : $urandom_range(1, 3);
      repeat (run) add_char((r < 75) ? CH_LT : CH_GT, 1'b0);
    end else if (r < 90) begin
      add_char(random_letter(), 1'b1);
    end else begin
      add_char(SYMBOL_W'($urandom_range(255)), ($urandom_range(19) == 0));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      clear_parser();
    end else begin
      if (in_tvalid && in_tready) begin
        parse_char(mnp_item_t'({in_tdata, in_tuser}));
        chars_taken <= chars_taken + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (track_chars.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          in_tvalid <= 1'b1;
          in_tdata <= track_chars[0].symbol;
          in_tuser <= track_chars[0].track_start;
          void'(track_chars.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= idle_pct(1'b0));
  end

  always @(posedge clk) begin
    mnp_note_t got;
    mnp_note_t want;
    int unsigned bad;
    bad = 0;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(mnp_note_t)-1:0];
      if (expected_notes.size() == 0) begin
        $display("%0t: unexpected note, actual %h", $time, got);
        bad = bad + 1;
      end else begin
        want = expected_notes.pop_front();
        if (got.note_seq != want.note_seq) begin
          $display("%0t: note_seq expected %0d actual %0d", $time,
                   want.note_seq, got.note_seq);
          bad = bad + 1;
        end
        if (got.slot_index != want.slot_index) begin
          $display("%0t: slot_index expected %0d actual %0d", $time,
                   want.slot_index, got.slot_index);
          bad = bad + 1;
        end
        if (got.note_length != want.note_length) begin
          $display("%0t: note_length expected %0d actual %0d", $time,
                   want.note_length, got.note_length);
          bad = bad + 1;
        end
        if (got.key_number != want.key_number) begin
          $display("%0t: key_number expected %0d actual %0d", $time,
                   want.key_number, got.key_number);
          bad = bad + 1;
        end
      end
      if (bad != 0) begin
        error_count <= error_count + bad;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    add_char(CH_C, 1'b1);
    add_char(CH_D, 1'b0);
    add_char(CH_E, 1'b0);
    add_char(CH_F, 1'b0);
    add_char(CH_G, 1'b0);
    add_char(CH_A, 1'b0);
    add_char(CH_B, 1'b0);
    add_char(CH_L, 1'b0);
    add_char(CH_DIG2, 1'b0);
    add_char(CH_C, 1'b0);
    add_char(CH_L, 1'b0);
    add_char(CH_L, 1'b0);
    add_char(CH_DIG8, 1'b0);
    add_char(CH_D, 1'b0);
    add_char(CH_L, 1'b0);
    add_char(SYM_NINE, 1'b0);
    add_char(CH_O, 1'b0);
    add_char(CH_C, 1'b0);
    add_char(CH_O, 1'b0);
    add_char(CH_DIG1 + 8'd2, 1'b0);
    add_char(CH_E, 1'b0);
    repeat (5) add_char(CH_LT, 1'b0);
    add_char(CH_A, 1'b0);
    add_char(SYM_LOWER_C, 1'b0);
    add_char(SYM_ALL_ONE, 1'b0);
    add_char(SYM_ZERO, 1'b1);
    add_char(CH_O, 1'b0);
    add_char(CH_DIG8, 1'b0);
    add_char(CH_G, 1'b0);

    while (track_chars.size() < RANDOM_ITEMS) add_random_phrase();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (track_chars.size() != 0 || in_tvalid || expected_notes.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (error_count == 0 && expected_notes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/mnp_pkg.sv
hw/rtl/mnp_in_stage.sv
hw/rtl/mnp_core.sv
hw/rtl/mnp_out_stage.sv
hw/rtl/mml_note_parser_top.sv
sim/testbench.sv
